[rtl/kli_pkg.sv]
package kli_pkg;

  localparam int MaxKeys = 256;
  localparam int IdxW = 8;

  typedef struct packed {
    logic        action;
    logic [7:0]  key_slot;
    logic [14:0] key_time;
    logic        step_flag;
    logic signed [31:0] key_value;
    logic [22:0] query_time;
    logic        use_hint;
    logic [7:0]  hint_index;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]  found_index;
  } out_beat_t;

  localparam logic ActLoad = 1'b0;
  localparam logic ActEval = 1'b1;

  typedef enum logic [3:0] {
    DpNop      = 4'd0,
    DpLoad     = 4'd1,
    DpStart    = 4'd2,
    DpRead     = 4'd3,
    DpBisEdges = 4'd4,
    DpBisStep  = 4'd5,
    DpWalkDown = 4'd6,
    DpWalkUp   = 4'd7,
    DpFinal    = 4'd8,
    DpDivStep  = 4'd9,
    DpMul      = 4'd10,
    DpOut      = 4'd11
  } dp_cmd_e;

  typedef struct packed {
    logic use_walk;
    logic search_done;
    logic hold;
    logic div_done;
  } dp_status_t;

endpackage

[rtl/keyframe_linear_interpolator.sv]
// Channel | dir | handshake     | beat
// in      | in  | valid / stall | kli_pkg::in_beat_t
// out     | out | valid / stall | kli_pkg::out_beat_t
// cfg     | in  | valid / ready | key_count, 9 bits
// A load writes the key table. An evaluate by binary search probes the registered
// key table, then runs a 16-step divider. A walk from a hint moves one key at a
// time, down and then up, until it brackets the query time.
// Reset is asynchronous, active low; key_count returns to 1, keys are unset.
// A stalled result is held in its output register; input stalls while busy.
module keyframe_linear_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  kli_pkg::in_beat_t  in_data_i,
  output logic               out_valid,
  input  logic               out_stall,
  output kli_pkg::out_beat_t out_data_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data_i
);

  kli_pkg::dp_cmd_e cmd;
  kli_pkg::dp_status_t status;
  logic idle;
  logic [8:0] key_count_q;

  assign cfg_ready = idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) key_count_q <= 9'd1;
    else if (cfg_valid && cfg_ready) key_count_q <= cfg_data_i;
  end

  kli_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .item_i(in_data_i),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_i(status), .cmd_o(cmd), .idle_o(idle)
  );

  kli_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i),
    .key_count_i(key_count_q), .status_o(status), .result_o(out_data_o)
  );

endmodule

[rtl/kli_datapath.sv]
module kli_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kli_pkg::dp_cmd_e  cmd_i,
  input  kli_pkg::in_beat_t item_i,
  input  logic [8:0]        key_count_i,
  output kli_pkg::dp_status_t status_o,
  output kli_pkg::out_beat_t  result_o
);

  localparam int MaxKeys = kli_pkg::MaxKeys;
  localparam int IdxW = kli_pkg::IdxW;
  localparam int CW = IdxW + 1;

  logic [15:0] times_mem [MaxKeys];
  logic [31:0] values_mem [MaxKeys];

  logic [IdxW-1:0] raddr_a, raddr_b;
  logic [15:0] ta_q, tb_q;
  logic [31:0] va_q, vb_q;

  logic [CW-1:0] cnt_q;
  logic [22:0] q_q;
  logic [14:0] tq;
  logic [IdxW-1:0] idx_q, idx_d, low_q, low_d, high_q, high_d;
  logic [1:0] phase_q, phase_d;
  logic done_q, done_d, walk_q, walk_d;
  logic [23:0] den_q, rem_q;
  logic [15:0] fac_q;
  logic [4:0] dcnt_q;
  logic signed [32:0] diff_q;
  logic signed [50:0] prod_q;
  kli_pkg::out_beat_t res_q;

  logic [CW-1:0] cnt_eff;
  always_comb begin
    logic [8:0] c;
    c = (key_count_i == 9'd0) ? 9'd1 : key_count_i;
    if ({1'b0, c} > 10'(MaxKeys)) cnt_eff = CW'(MaxKeys);
    else cnt_eff = CW'(c);
  end

  assign tq = q_q[22:8];

  always_comb begin
    raddr_a = idx_q;
    raddr_b = idx_q + 1'b1;
    unique case (cmd_i)
      kli_pkg::DpStart: begin
        raddr_a = '0;
        raddr_b = IdxW'(cnt_eff - 1'b1);
        if (item_i.use_hint && {1'b0, item_i.hint_index} < cnt_eff) begin
          raddr_a = item_i.hint_index;
          raddr_b = item_i.hint_index + 1'b1;
        end
      end
      kli_pkg::DpBisEdges, kli_pkg::DpBisStep: begin
        raddr_a = idx_d;
        raddr_b = idx_d + 1'b1;
      end
      kli_pkg::DpWalkDown, kli_pkg::DpWalkUp: begin
        raddr_a = idx_d;
        raddr_b = idx_d + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == kli_pkg::DpLoad && {1'b0, item_i.key_slot} < CW'(MaxKeys)) begin
      times_mem[IdxW'(item_i.key_slot)]  <= {item_i.step_flag, item_i.key_time};
      values_mem[IdxW'(item_i.key_slot)] <= item_i.key_value;
    end
    ta_q <= times_mem[raddr_a];
    tb_q <= times_mem[raddr_b];
    va_q <= values_mem[raddr_a];
    vb_q <= values_mem[raddr_b];
  end

  logic last_a;
  assign last_a = ({1'b0, idx_q} + 1'b1) >= CW'(cnt_q);

  always_comb begin
    idx_d = idx_q; low_d = low_q; high_d = high_q;
    phase_d = phase_q; done_d = done_q; walk_d = walk_q;
    unique case (cmd_i)
      kli_pkg::DpStart: begin
        done_d = 1'b0; phase_d = 2'd0;
        walk_d = item_i.use_hint && {1'b0, item_i.hint_index} < cnt_eff;
        idx_d = walk_d ? item_i.hint_index : '0;
      end
      kli_pkg::DpBisEdges: begin
        if (tq <= ta_q[14:0]) begin
          idx_d = '0; done_d = 1'b1;
        end else if (tq >= tb_q[14:0]) begin
          idx_d = IdxW'(cnt_q - 1'b1); done_d = 1'b1;
        end else begin
          low_d = '0; high_d = IdxW'(cnt_q - 2'd2);
          idx_d = IdxW'((CW'(cnt_q) - 2'd2) >> 1);
        end
      end
      kli_pkg::DpBisStep: begin
        if (tq < ta_q[14:0]) begin
          if (high_q == idx_q) done_d = 1'b1;
          else high_d = idx_q;
        end else if (tq >= tb_q[14:0]) begin
          if (low_q != idx_q) low_d = idx_q; else low_d = low_q + 1'b1;
          if ({1'b0, low_d} > {1'b0, high_q} || (low_q == idx_q && low_q == '1))
            done_d = 1'b1;
        end else done_d = 1'b1;
        if (!done_d) idx_d = IdxW'(({1'b0, low_d} + {1'b0, high_d}) >> 1);
      end
      kli_pkg::DpWalkDown: begin
        if (phase_q == 2'd0) begin
          if (idx_q != '0 && ta_q[14:0] > tq) idx_d = idx_q - 1'b1;
          else phase_d = 2'd1;
        end
        if (phase_q == 2'd1) begin
          if (!last_a && tb_q[14:0] <= tq) idx_d = idx_q + 1'b1;
          else done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic hold;
  assign hold = last_a || tb_q[15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0; walk_q <= 1'b0; phase_q <= '0;
    end else begin
      done_q <= done_d; walk_q <= walk_d; phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; low_q <= low_d; high_q <= high_d;
    if (cmd_i == kli_pkg::DpStart) begin
      cnt_q <= cnt_eff;
      q_q <= item_i.query_time;
    end
    unique case (cmd_i)
      kli_pkg::DpFinal: begin
        logic [23:0] t0s, t1s;
        t0s = {1'b0, ta_q[14:0], 8'd0};
        t1s = {1'b0, tb_q[14:0], 8'd0};
        diff_q <= $signed({vb_q[31], vb_q}) - $signed({va_q[31], va_q});
        if (tb_q[14:0] <= ta_q[14:0] || {1'b0, q_q} <= t0s) begin
          fac_q <= 16'h0; dcnt_q <= 5'd16;
        end else if ({1'b0, q_q} - t0s >= t1s - t0s) begin
          fac_q <= 16'hFFFF; dcnt_q <= 5'd16;
        end else begin
          fac_q <= '0;
          dcnt_q <= '0;
          rem_q <= {1'b0, q_q} - t0s;
          den_q <= t1s - t0s;
        end
      end
      kli_pkg::DpDivStep: begin
        if (dcnt_q != 5'd16) begin
          logic [24:0] r;
          r = {rem_q, 1'b0};
          if (r >= {1'b0, den_q}) begin
            rem_q <= 24'(r - {1'b0, den_q});
            fac_q <= {fac_q[14:0], 1'b1};
          end else begin
            rem_q <= r[23:0];
            fac_q <= {fac_q[14:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 1'b1;
        end
      end
      kli_pkg::DpMul: prod_q <= diff_q * $signed({1'b0, fac_q});
      kli_pkg::DpOut: begin
        res_q.found_index <= idx_q;
        if (hold) res_q.value <= va_q;
        else res_q.value <= 32'($signed(va_q) + $signed(prod_q[50:16]));
      end
      default: ;
    endcase
  end

  // The numerator is below the denominator, so sixteen restoring steps on a
  // remainder preloaded with the numerator give numerator * 65536 / denominator.
  assign status_o.use_walk = walk_q;
  assign status_o.search_done = done_q;
  assign status_o.hold = hold;
  assign status_o.div_done = (dcnt_q == 5'd16);
  assign result_o = res_q;

endmodule

[rtl/kli_ctrl.sv]
module kli_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kli_pkg::in_beat_t   item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  kli_pkg::dp_status_t status_i,
  output kli_pkg::dp_cmd_e    cmd_o,
  output logic                idle_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StEdges = 8'b0000_0010,
    StBis   = 8'b0000_0100,
    StWalk  = 8'b0000_1000,
    StRead  = 8'b0001_0000,
    StDiv   = 8'b0010_0000,
    StMul   = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d, rd_q, rd_d;
  logic take;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && !out_stall_i);
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o = kli_pkg::DpNop;
    out_valid_d = out_valid_q && out_stall_i;
    rd_d = 1'b0;
    unique case (state_q)
      StIdle: if (take) begin
        if (item_i.action == kli_pkg::ActLoad) cmd_o = kli_pkg::DpLoad;
        else begin
          cmd_o = kli_pkg::DpStart;
          state_d = StEdges;
        end
      end
      StEdges: begin
        if (status_i.use_walk) state_d = StWalk;
        else begin
          cmd_o = kli_pkg::DpBisEdges;
          state_d = StBis;
        end
      end
      StBis: begin
        if (status_i.search_done) state_d = StRead;
        else if (rd_q) cmd_o = kli_pkg::DpBisStep;
        rd_d = !rd_q && !status_i.search_done;
      end
      StWalk: begin
        if (!status_i.use_walk) state_d = StEdges;
        else if (status_i.search_done) state_d = StRead;
        else if (rd_q) cmd_o = kli_pkg::DpWalkDown;
        rd_d = !rd_q;
      end
      StRead: begin
        rd_d = 1'b1;
        if (rd_q) begin
          cmd_o = kli_pkg::DpFinal;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o = kli_pkg::DpDivStep;
        if (status_i.div_done) begin
          cmd_o = kli_pkg::DpMul;
          state_d = StMul;
        end
      end
      StMul: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o = kli_pkg::DpOut;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      rd_q <= rd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign idle_o = (state_q == StIdle);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul && cmd_o == kli_pkg::DpOut) |=> out_valid_q)
    else $error("result not raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("result dropped under stall");

endmodule
